// ----- hw/rtl/icc_pkg.sv -----
// ----------------------------------------------------------------------------
// icc_pkg: shared types, codes and command table for the IRC command classifier
// Holds the parse phase type, the message kind codes and the token matcher.
// ----------------------------------------------------------------------------
package icc_pkg;

  // Command token storage
  localparam int TOKEN_MAX = 7;
  localparam int NUM_WORDS = 20;

  typedef logic [TOKEN_MAX-1:0][7:0] token_t;
  typedef logic [3:0]                token_len_t;
  typedef logic [4:0]                kind_t;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,
    PH_PREFIX = 4'b0010,
    PH_CMD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Delimiters
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Message kind codes
  localparam kind_t KIND_INVALID     = 5'd0;
  localparam kind_t KIND_UNKNOWN     = 5'd1;
  localparam kind_t KIND_PRIVMSG     = 5'd2;
  localparam kind_t KIND_NOTICE      = 5'd3;
  localparam kind_t KIND_MODE        = 5'd4;
  localparam kind_t KIND_JOIN        = 5'd5;
  localparam kind_t KIND_PART        = 5'd6;
  localparam kind_t KIND_PING        = 5'd7;
  localparam kind_t KIND_PONG        = 5'd8;
  localparam kind_t KIND_NICK        = 5'd9;
  localparam kind_t KIND_QUIT        = 5'd10;
  localparam kind_t KIND_KICK        = 5'd11;
  localparam kind_t KIND_KILL        = 5'd12;
  localparam kind_t KIND_INVITE      = 5'd13;
  localparam kind_t KIND_TOPIC       = 5'd14;
  localparam kind_t KIND_TOPIC_ORIG  = 5'd15;
  localparam kind_t KIND_WHO         = 5'd16;
  localparam kind_t KIND_NAMES       = 5'd17;
  localparam kind_t KIND_CHANMODE1   = 5'd18;
  localparam kind_t KIND_CHANMODE2   = 5'd19;

  // Command table. Strings are right-justified: character i of a word of
  // length L sits in byte L-1-i.
  localparam token_t WORD_TEXT [NUM_WORDS] = '{
    56'("PRIVMSG"), 56'("NOTICE"), 56'("MODE"), 56'("JOIN"),
    56'("PART"), 56'("PING"), 56'("PONG"), 56'("NICK"),
    56'("QUIT"), 56'("KICK"), 56'("KILL"), 56'("INVITE"),
    56'("332"), 56'("TOPIC"), 56'("333"), 56'("352"),
    56'("353"), 56'("NAMES"), 56'("324"), 56'("329")
  };

  localparam token_len_t WORD_LEN [NUM_WORDS] = '{
    4'd7, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd3, 4'd3, 4'd5, 4'd3, 4'd3
  };

  localparam kind_t WORD_KIND [NUM_WORDS] = '{
    KIND_PRIVMSG, KIND_NOTICE, KIND_MODE, KIND_JOIN, KIND_PART,
    KIND_PING, KIND_PONG, KIND_NICK, KIND_QUIT, KIND_KICK,
    KIND_KILL, KIND_INVITE, KIND_TOPIC, KIND_TOPIC, KIND_TOPIC_ORIG,
    KIND_WHO, KIND_NAMES, KIND_NAMES, KIND_CHANMODE1, KIND_CHANMODE2
  };

  // Fold ASCII a-z to upper case, other bytes pass unchanged
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      return c & ~CASE_BIT;
    end
    return c;
  endfunction

  // Match a token against the table; first hit in table order wins.
  // Only entries below len are compared, so unwritten entries never matter.
  function automatic kind_t classify_token(input token_t tok, input token_len_t len);
    kind_t kind;
    logic  hit;
    logic  same;
    kind = KIND_UNKNOWN;
    hit  = 1'b0;
    if (len <= token_len_t'(TOKEN_MAX)) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        same = (WORD_LEN[w] == len);
        for (int i = 0; i < TOKEN_MAX; i++) begin
          if (token_len_t'(i) < WORD_LEN[w]) begin
            if (tok[3'(i)] != WORD_TEXT[w][3'(int'(WORD_LEN[w]) - 1 - i)]) begin
              same = 1'b0;
            end
          end
        end
        if (same && !hit) begin
          kind = WORD_KIND[w];
          hit  = 1'b1;
        end
      end
    end
    return kind;
  endfunction

endpackage

// ----- hw/rtl/irc_command_classifier.sv -----
// ----------------------------------------------------------------------------
// irc_command_classifier: per-byte IRC line parser giving one message kind
// Tracks the line phase, keeps the upper-cased command token and classifies
// the line when its last byte is taken in.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload              | items
//  --------+-------------------------+----------------------+------------------
//  line    | line_valid / line_ready | line_byte, line_end  | one byte per item
//  kind    | kind_valid / kind_ready | msg_kind             | one per line end
//
//  One byte is taken every cycle while line_ready is high; the kind for a line
//  enters the output register in the cycle after its last byte is accepted.
//  The classify path is one pass of byte compares against the command table
//  between the parser state and the output register. line_ready drops only
//  while a finished kind waits and kind_ready is low. Reset (rst, synchronous)
//  returns the parser to the first-byte phase and empties the output register.
//
module irc_command_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       line_valid,
  output logic       line_ready,
  input  logic [7:0] line_byte,
  input  logic       line_end,
  output logic       kind_valid,
  input  logic       kind_ready,
  output logic [4:0] msg_kind
);

  icc_pkg::phase_t     phase, phase_next;
  icc_pkg::token_t     token, token_next;
  icc_pkg::token_len_t token_length, token_length_next;
  logic                line_invalid, line_invalid_next;
  icc_pkg::kind_t      kind_next;
  logic                accept;

  assign line_ready = !kind_valid || kind_ready;
  assign accept     = line_valid && line_ready;

  // Parser step for the byte on the input
  always_comb begin
    phase_next        = phase;
    token_next        = token;
    token_length_next = token_length;
    line_invalid_next = line_invalid;
    case (phase)
      icc_pkg::PH_FIRST: begin
        if (line_byte == icc_pkg::CHAR_COLON) begin
          phase_next = icc_pkg::PH_PREFIX;
        end else begin
          line_invalid_next = 1'b1;
          phase_next        = icc_pkg::PH_DONE;
        end
      end
      icc_pkg::PH_PREFIX: begin
        if (line_byte == icc_pkg::CHAR_SPACE) begin
          phase_next = icc_pkg::PH_CMD;
        end else if (line_byte == icc_pkg::CHAR_NUL) begin
          line_invalid_next = 1'b1;
          phase_next        = icc_pkg::PH_DONE;
        end
      end
      icc_pkg::PH_CMD: begin
        if (line_byte == icc_pkg::CHAR_SPACE || line_byte == icc_pkg::CHAR_NUL) begin
          phase_next = icc_pkg::PH_DONE;
        end else begin
          // store up to seven chars, count saturates at eight
          if (token_length < icc_pkg::token_len_t'(icc_pkg::TOKEN_MAX)) begin
            token_next[token_length[2:0]] = icc_pkg::fold_upper(line_byte);
          end
          if (token_length <= icc_pkg::token_len_t'(icc_pkg::TOKEN_MAX)) begin
            token_length_next = token_length + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Kind of the line if this byte ends it
  always_comb begin
    if (line_invalid_next || phase_next == icc_pkg::PH_FIRST ||
        phase_next == icc_pkg::PH_PREFIX) begin
      kind_next = icc_pkg::KIND_INVALID;
    end else begin
      kind_next = icc_pkg::classify_token(token_next, token_length_next);
    end
  end

  // Parser control state; a line end starts a new line
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= icc_pkg::PH_FIRST;
      token_length <= '0;
      line_invalid <= 1'b0;
    end else if (accept) begin
      if (line_end) begin
        phase        <= icc_pkg::PH_FIRST;
        token_length <= '0;
        line_invalid <= 1'b0;
      end else begin
        phase        <= phase_next;
        token_length <= token_length_next;
        line_invalid <= line_invalid_next;
      end
    end
  end

  // Token characters, no reset
  always_ff @(posedge clk) begin
    if (accept && !line_end) begin
      token <= token_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_valid <= 1'b0;
    end else if (accept && line_end) begin
      kind_valid <= 1'b1;
    end else if (kind_ready) begin
      kind_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && line_end) begin
      msg_kind <= kind_next;
    end
  end

  // Checks
  a_kind_follows_end: assert property (@(posedge clk) disable iff (rst)
    accept && line_end |=> kind_valid)
    else $error("kind missing after line end");

  a_bad_first_byte: assert property (@(posedge clk) disable iff (rst)
    accept && line_end && phase == icc_pkg::PH_FIRST &&
    line_byte != icc_pkg::CHAR_COLON |=> msg_kind == icc_pkg::KIND_INVALID)
    else $error("line without colon not invalid");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    kind_valid |-> msg_kind <= icc_pkg::KIND_CHANMODE2)
    else $error("kind out of range");

  a_new_line: assert property (@(posedge clk) disable iff (rst)
    accept && line_end |=> phase == icc_pkg::PH_FIRST && token_length == '0 &&
    !line_invalid)
    else $error("parser not cleared after line end");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for irc_command_classifier
// Streams IRC line bytes into the classifier through a queue-fed driver, keeps
// a cycle-free model of the line parser and checks every message kind that
// comes out against it, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int LINE_ITEMS     = 650;
  localparam int QUIET_TAIL     = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } line_item_t;

  logic       clk;
  logic       rst        = 1'b1;
  logic       line_valid = 1'b0;
  logic       line_ready;
  logic [7:0] line_byte  = 8'h00;
  logic       line_end   = 1'b0;
  logic       kind_valid;
  logic       kind_ready = 1'b0;
  logic [4:0] msg_kind;

  // Stimulus and expectation stores
  line_item_t         pending_bytes[$];
  icc_pkg::kind_t     expected_kinds[$];
  logic [7:0]         line_buf[$];

  // Line parser model state
  icc_pkg::phase_t     parse_state = icc_pkg::PH_FIRST;
  logic [7:0]          cmd_chars [icc_pkg::TOKEN_MAX];
  icc_pkg::token_len_t cmd_len  = '0;
  logic                line_bad = 1'b0;

  // Handshake bookkeeping
  bit byte_taken   = 1'b0;
  bit quiet        = 1'b0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int idle_cycles  = 0;
  int mismatches   = 0;

  string cmd_words [20] = '{
    "PRIVMSG", "NOTICE", "MODE", "JOIN", "PART", "PING", "PONG", "NICK",
    "QUIT", "KICK", "KILL", "INVITE", "332", "TOPIC", "333", "352",
    "353", "NAMES", "324", "329"
  };

  irc_command_classifier u_dut (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line_byte  (line_byte),
    .line_end   (line_end),
    .kind_valid (kind_valid),
    .kind_ready (kind_ready),
    .msg_kind   (msg_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line parser model
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] upcase(input logic [7:0] b);
    if (b >= icc_pkg::CHAR_LOW_A && b <= icc_pkg::CHAR_LOW_Z) begin
      return b - 8'd32;
    end
    return b;
  endfunction

  // Token chars are never zero, so the right-aligned pack also fixes the length
  function automatic icc_pkg::kind_t command_kind();
    logic [55:0]    packed_cmd;
    icc_pkg::kind_t kind;
    packed_cmd = '0;
    kind       = icc_pkg::KIND_UNKNOWN;
    if (cmd_len <= icc_pkg::token_len_t'(icc_pkg::TOKEN_MAX)) begin
      for (int i = 0; i < int'(cmd_len); i++) begin
        packed_cmd = {packed_cmd[47:0], cmd_chars[i]};
      end
      case (packed_cmd)
        "PRIVMSG":      kind = icc_pkg::KIND_PRIVMSG;
        "NOTICE":       kind = icc_pkg::KIND_NOTICE;
        "MODE":         kind = icc_pkg::KIND_MODE;
        "JOIN":         kind = icc_pkg::KIND_JOIN;
        "PART":         kind = icc_pkg::KIND_PART;
        "PING":         kind = icc_pkg::KIND_PING;
        "PONG":         kind = icc_pkg::KIND_PONG;
        "NICK":         kind = icc_pkg::KIND_NICK;
        "QUIT":         kind = icc_pkg::KIND_QUIT;
        "KICK":         kind = icc_pkg::KIND_KICK;
        "KILL":         kind = icc_pkg::KIND_KILL;
        "INVITE":       kind = icc_pkg::KIND_INVITE;
        "332", "TOPIC": kind = icc_pkg::KIND_TOPIC;
        "333":          kind = icc_pkg::KIND_TOPIC_ORIG;
        "352":          kind = icc_pkg::KIND_WHO;
        "353", "NAMES": kind = icc_pkg::KIND_NAMES;
        "324":          kind = icc_pkg::KIND_CHANMODE1;
        "329":          kind = icc_pkg::KIND_CHANMODE2;
        default:        kind = icc_pkg::KIND_UNKNOWN;
      endcase
    end
    return kind;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    case (parse_state)
      icc_pkg::PH_FIRST: begin
        if (b == icc_pkg::CHAR_COLON) begin
          parse_state = icc_pkg::PH_PREFIX;
        end else begin
          line_bad    = 1'b1;
          parse_state = icc_pkg::PH_DONE;
        end
      end
      icc_pkg::PH_PREFIX: begin
        if (b == icc_pkg::CHAR_SPACE) begin
          parse_state = icc_pkg::PH_CMD;
        end else if (b == icc_pkg::CHAR_NUL) begin
          line_bad    = 1'b1;
          parse_state = icc_pkg::PH_DONE;
        end
      end
      icc_pkg::PH_CMD: begin
        if (b == icc_pkg::CHAR_SPACE || b == icc_pkg::CHAR_NUL) begin
          parse_state = icc_pkg::PH_DONE;
        end else begin
          if (cmd_len < icc_pkg::token_len_t'(icc_pkg::TOKEN_MAX)) begin
            cmd_chars[cmd_len[2:0]] = upcase(b);
          end
          if (cmd_len <= icc_pkg::token_len_t'(icc_pkg::TOKEN_MAX)) cmd_len = cmd_len + 4'd1;
        end
      end
      default: ;
    endcase
    // A line end yields one kind and restarts the parser
    if (last) begin
      if (line_bad || parse_state == icc_pkg::PH_FIRST ||
          parse_state == icc_pkg::PH_PREFIX) begin
        expected_kinds.push_back(icc_pkg::KIND_INVALID);
      end else begin
        expected_kinds.push_back(command_kind());
      end
      parse_state = icc_pkg::PH_FIRST;
      cmd_len     = '0;
      line_bad    = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] token_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == icc_pkg::CHAR_SPACE) b = 8'h21;
    return b;
  endfunction

  task automatic add_text(input string s, input bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1)) c = c + 8'd32;
      line_buf.push_back(c);
    end
  endtask

  task automatic close_line(input bit drain);
    for (int i = 0; i < line_buf.size(); i++) begin
      pending_bytes.push_back('{line_buf[i], i == line_buf.size() - 1, drain && i == 0});
    end
    line_buf.delete();
  endtask

  task automatic build_stimulus();
    int n;
    int pick;
    // Directed lines: bad first bytes, zero in prefix, empty, too long, etc.
    line_buf.push_back(8'hFF);                   close_line(1'b0);
    line_buf.push_back(icc_pkg::CHAR_NUL);       close_line(1'b0);
    add_text(":", 1'b0);                         close_line(1'b0);
    add_text(":a", 1'b0); line_buf.push_back(icc_pkg::CHAR_NUL);
    add_text(" x", 1'b0);                        close_line(1'b0);
    add_text(":  x", 1'b0);                      close_line(1'b0);
    add_text(": ", 1'b0);                        close_line(1'b0);
    add_text(": PrIvMsG", 1'b0);                 close_line(1'b0);
    add_text(": privmsgX", 1'b0);                close_line(1'b0);
    add_text(": 332", 1'b0); line_buf.push_back(icc_pkg::CHAR_NUL);
    line_buf.push_back(8'hFF);                   close_line(1'b0);
    add_text(": namez x", 1'b0);                 close_line(1'b0);

    // Random lines, mostly well formed; the first one waits for a full drain
    n = 0;
    while (pending_bytes.size() < LINE_ITEMS) begin
      if ($urandom_range(0, 99) < 72) begin
        line_buf.push_back(icc_pkg::CHAR_COLON);
        repeat ($urandom_range(0, 4)) line_buf.push_back(token_byte());
        line_buf.push_back(icc_pkg::CHAR_SPACE);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          add_text(cmd_words[$urandom_range(0, 19)], 1'b1);
        end else if (pick < 75) begin
          line_buf.push_back("3");
          line_buf.push_back(8'h30 + 8'($urandom_range(0, 5)));
          line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 9)) line_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
        end else if (pick < 95) begin
          repeat ($urandom_range(1, 3)) line_buf.push_back(token_byte());
        end
        if ($urandom_range(0, 1)) begin
          line_buf.push_back(icc_pkg::CHAR_SPACE);
          repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        // Noise: arbitrary bytes, sometimes behind a colon
        if ($urandom_range(0, 1)) line_buf.push_back(icc_pkg::CHAR_COLON);
        repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      close_line(n == 0 || $urandom_range(0, 49) == 0);
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: model update on accepted bytes, check on accepted kinds
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (kind_valid && kind_ready) begin
        if (expected_kinds.size() == 0) begin
          if (mismatches < MAX_REPORTS) $display("unexpected item: msg_kind %0d", msg_kind);
          mismatches++;
        end else begin
          if (msg_kind !== expected_kinds[0]) begin
            if (mismatches < MAX_REPORTS) begin
              $display("mismatch: msg_kind expected %0d, got %0d", expected_kinds[0], msg_kind);
            end
            mismatches++;
          end
          void'(expected_kinds.pop_front());
        end
      end
      if (line_valid && line_ready) parse_byte(line_byte, line_end);
      byte_taken = line_valid && line_ready;
      quiet      = pending_bytes.size() < QUIET_TAIL;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bytes from the pending queue, with random gaps and drain pauses
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_line
    line_item_t item;
    if (!rst) begin
      if (line_valid && !byte_taken) begin
        // hold the current item until it is taken
      end else if (send_gap != 0) begin
        send_gap--;
        line_valid <= 1'b0;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].drain && expected_kinds.size() != 0)) begin
        item = pending_bytes.pop_front();
        line_byte  <= item.data;
        line_end   <= item.last;
        line_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
      end else begin
        line_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls in bursts
  always @(negedge clk) begin
    if (rst) begin
      kind_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      kind_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 16) - 1;
      kind_ready <= 1'b0;
    end else begin
      kind_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((line_valid && line_ready) || (kind_valid && kind_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Sequencing: build, reset, drain, final verdict
  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0 || line_valid || expected_kinds.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
